FILE: src/perspective_box_projection_assert.svh
// Assertion macros used by the checker file of the box projection block.
`ifndef PERSPECTIVE_BOX_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_BOX_PROJECTION_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define PBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define PBP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/pbp_pkg.sv
// Shared widths and register indexes of the perspective box projection block.
package pbp_pkg;

  localparam int unsigned COORD_W         = 32;
  localparam int unsigned BOX_W           = 16;
  localparam int unsigned HALF_W          = 13;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned RATIO_INT_BITS  = 20;
  localparam int unsigned DIV_STEPS       = 4;
  localparam int          BOX_MAX         = 32767;
  localparam int          BOX_MIN         = -32768;
  localparam logic [12:0] HALF_W_RESET    = 13'd960;
  localparam logic [12:0] HALF_H_RESET    = 13'd540;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_B = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_W = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_H = 3'd7;

endpackage

FILE: src/pbp_if.sv
// Valid/ready channel interfaces for world points and screen boxes.
interface pbp_in_if;
  import pbp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] loc_x;
  logic signed [COORD_W-1:0] loc_y;
  logic signed [COORD_W-1:0] loc_z;
  modport source (output valid, output loc_x, output loc_y, output loc_z, input ready);
  modport sink (input valid, input loc_x, input loc_y, input loc_z, output ready);
endinterface

interface pbp_out_if;
  import pbp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    visible;
  logic signed [BOX_W-1:0] box_left;
  logic signed [BOX_W-1:0] box_top;
  logic signed [BOX_W-1:0] box_width;
  logic signed [BOX_W-1:0] box_height;
  modport source (output valid, output visible, output box_left, output box_top,
                  output box_width, output box_height, input ready);
  modport sink (input valid, input visible, input box_left, input box_top,
                input box_width, input box_height, output ready);
endinterface

FILE: src/perspective_box_projection.sv
// Pipelined world-to-screen projection of a point into an on-screen box.
// Accepts one world point per clock while no result waits downstream, and
// returns one box per point, in order. Three stages form the products, the
// dot products and the depth test with magnitudes, the three ratios are
// restoring long divisions that retire four quotient bits per stage, and three
// stages scale, combine and saturate the box. When the output is not taken the
// whole pipeline holds, so ready drops only while a result waits downstream.
// Matrix and window registers are written through the plain write port, by the
// user only while no point is in flight; the block does not enforce it.
module perspective_box_projection #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned SCREEN_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pbp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pbp_in_if.sink                         in_i,
  pbp_out_if.source                      out_o
);
  import pbp_pkg::*;

  localparam int unsigned PROD_W = 2 * COORD_W;
  localparam int unsigned AW     = PROD_W - FRAC_BITS + 3;
  localparam int unsigned MAG_W  = RATIO_INT_BITS + SCREEN_BITS;
  localparam int unsigned DIV_ST = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned RAT_W  = MAG_W + 1;
  localparam int unsigned SP_W   = RAT_W + HALF_W + 1;
  localparam int unsigned SW     = SP_W + 1;
  localparam int unsigned LW     = SW + 3;

  localparam logic signed [AW-1:0] DEPTH_MIN = AW'(((1 << FRAC_BITS) + 99) / 100);
  localparam logic signed [LW-1:0] SAT_HI    = LW'(BOX_MAX);
  localparam logic signed [LW-1:0] SAT_LO    = LW'(BOX_MIN);

  typedef struct packed {
    logic [AW-1:0]    r;
    logic [MAG_W-1:0] q;
  } div_t;

  // Restoring division steps; quotient bits enter MSB first.
  function automatic div_t div_steps(input logic [AW-1:0] r, input logic [AW-1:0] d,
                                     input logic [AW-1:0] a, input logic [MAG_W-1:0] q,
                                     input int base);
    logic [AW:0] t;
    logic        nb;
    int          i;
    div_t        res;
    for (int k = 0; k < int'(DIV_STEPS); k++) begin
      i = base - k;
      if (i >= 0) begin
        nb = (i >= int'(SCREEN_BITS)) ? a[i - int'(SCREEN_BITS)] : 1'b0;
        t  = {r, nb};
        if (t >= {1'b0, d}) begin
          t = t - {1'b0, d};
          q = {q[MAG_W-2:0], 1'b1};
        end else begin
          q = {q[MAG_W-2:0], 1'b0};
        end
        r = t[AW-1:0];
      end
    end
    res.r = r;
    res.q = q;
    return res;
  endfunction

  // Truncate toward zero by 2^k, then clamp to the box range.
  function automatic logic [BOX_W-1:0] trunc_sat(input logic signed [LW-1:0] v, input int k);
    logic signed [LW-1:0] bias;
    logic signed [LW-1:0] t;
    bias = '0;
    if (v[LW-1]) bias = (LW'(1) << k) - LW'(1);
    t = (v + bias) >>> k;
    if (t > SAT_HI) t = SAT_HI;
    if (t < SAT_LO) t = SAT_LO;
    return t[BOX_W-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_DATA_W-1:0] row_q [6];
  logic [HALF_W-1:0]     hw_q;
  logic [HALF_W-1:0]     hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) row_q[i] <= '0;
      hw_q <= HALF_W_RESET;
      hh_q <= HALF_H_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        [CFG_ROW0_A:CFG_ROW2_B]: row_q[cfg_idx_i] <= cfg_data_i;
        CFG_HALF_W:              hw_q <= cfg_data_i[HALF_W-1:0];
        CFG_HALF_H:              hh_q <= cfg_data_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [COORD_W-1:0] m [3][4];
  for (genvar r = 0; r < 3; r++) begin : g_coef
    assign m[r][0] = row_q[2*r][COORD_W-1:0];
    assign m[r][1] = row_q[2*r][CFG_DATA_W-1:COORD_W];
    assign m[r][2] = row_q[2*r+1][COORD_W-1:0];
    assign m[r][3] = row_q[2*r+1][CFG_DATA_W-1:COORD_W];
  end

  // ---------------- pipeline control ----------------
  logic out_vld_q;
  logic adv;
  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  logic signed [COORD_W-1:0] crd [3];
  assign crd[0] = in_i.loc_x;
  assign crd[1] = in_i.loc_y;
  assign crd[2] = in_i.loc_z;

  // ---------------- S1: products ----------------
  logic                     v1_q;
  logic signed [PROD_W-1:0] p1_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p1_q[r][c] <= PROD_W'(m[r][c]) * PROD_W'(crd[c]);
        end
      end
    end
  end

  // ---------------- S2: dot products ----------------
  logic                 v2_q;
  logic signed [AW-1:0] d2_q, nx2_q, nt2_q, nb2_q;
  logic signed [AW-1:0] acc [3];
  logic signed [AW-1:0] m12x;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AW'(p1_q[r][0] >>> FRAC_BITS) + AW'(p1_q[r][1] >>> FRAC_BITS)
             + AW'(p1_q[r][2] >>> FRAC_BITS) + AW'(m[r][3]);
    end
    m12x = AW'(m[1][2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_q  <= acc[2];
      nx2_q <= acc[0];
      // top raised by 75, bottom lowered by 5, both scaled by the z column
      nt2_q <= acc[1] + (m12x <<< 6) + (m12x <<< 3) + (m12x <<< 1) + m12x;
      nb2_q <= acc[1] - (m12x <<< 2) - m12x;
    end
  end

  // ---------------- S3: depth test and magnitudes ----------------
  logic          v3_q, vis3_q;
  logic [AW-1:0] d3_q;
  logic [AW-1:0] a3_q [3];
  logic          neg3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis3_q    <= d2_q >= DEPTH_MIN;
      d3_q      <= d2_q;
      neg3_q[0] <= nx2_q[AW-1];
      neg3_q[1] <= nt2_q[AW-1];
      neg3_q[2] <= nb2_q[AW-1];
      a3_q[0]   <= nx2_q[AW-1] ? AW'(-nx2_q) : nx2_q;
      a3_q[1]   <= nt2_q[AW-1] ? AW'(-nt2_q) : nt2_q;
      a3_q[2]   <= nb2_q[AW-1] ? AW'(-nb2_q) : nb2_q;
    end
  end

  // ---------------- divider stages ----------------
  logic             dv_v_q   [DIV_ST];
  logic             dv_vis_q [DIV_ST];
  logic [AW-1:0]    dv_d_q   [DIV_ST];
  logic [AW-1:0]    dv_a_q   [DIV_ST][3];
  logic [AW-1:0]    dv_r_q   [DIV_ST][3];
  logic [MAG_W-1:0] dv_qt_q  [DIV_ST][3];
  logic             dv_ovf_q [DIV_ST][3];
  logic             dv_neg_q [DIV_ST][3];

  for (genvar s = 0; s < DIV_ST; s++) begin : g_div
    logic             src_v, src_vis;
    logic [AW-1:0]    src_d;
    logic [AW-1:0]    src_a [3];
    logic [AW-1:0]    src_r [3];
    logic [MAG_W-1:0] src_q [3];
    logic             src_ovf [3];
    logic             src_neg [3];

    if (s == 0) begin : g_src
      // ratio of 2^20 or more saturates; otherwise start from a >> 20
      always_comb begin
        src_v   = v3_q;
        src_vis = vis3_q;
        src_d   = d3_q;
        for (int l = 0; l < 3; l++) begin
          src_a[l]   = a3_q[l];
          src_r[l]   = a3_q[l] >> RATIO_INT_BITS;
          src_q[l]   = '0;
          src_ovf[l] = (a3_q[l] >> RATIO_INT_BITS) >= d3_q;
          src_neg[l] = neg3_q[l];
        end
      end
    end else begin : g_src
      always_comb begin
        src_v   = dv_v_q[s-1];
        src_vis = dv_vis_q[s-1];
        src_d   = dv_d_q[s-1];
        for (int l = 0; l < 3; l++) begin
          src_a[l]   = dv_a_q[s-1][l];
          src_r[l]   = dv_r_q[s-1][l];
          src_q[l]   = dv_qt_q[s-1][l];
          src_ovf[l] = dv_ovf_q[s-1][l];
          src_neg[l] = dv_neg_q[s-1][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[s] <= 1'b0;
      else if (adv) dv_v_q[s] <= src_v;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_vis_q[s] <= src_vis;
        dv_d_q[s]   <= src_d;
        for (int l = 0; l < 3; l++) begin
          div_t res;
          res = div_steps(src_r[l], src_d, src_a[l], src_q[l],
                          int'(MAG_W) - 1 - s * int'(DIV_STEPS));
          dv_a_q[s][l]   <= src_a[l];
          dv_r_q[s][l]   <= res.r;
          dv_qt_q[s][l]  <= res.q;
          dv_ovf_q[s][l] <= src_ovf[l];
          dv_neg_q[s][l] <= src_neg[l];
        end
      end
    end
  end

  // ---------------- P1: signed ratios times half window ----------------
  localparam int unsigned LAST = DIV_ST - 1;

  logic                    pv1_q, pvis1_q;
  logic signed [SP_W-1:0]  px_q, pt_q, pb_q;
  logic signed [RAT_W-1:0] rat [3];
  logic [MAG_W-1:0]        mag [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = dv_ovf_q[LAST][l] ? {MAG_W{1'b1}} : dv_qt_q[LAST][l];
      rat[l] = dv_neg_q[LAST][l] ? -$signed(RAT_W'(mag[l])) : $signed(RAT_W'(mag[l]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv1_q <= 1'b0;
    else if (adv) pv1_q <= dv_v_q[LAST];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pvis1_q <= dv_vis_q[LAST];
      px_q    <= SP_W'(rat[0]) * SP_W'($signed({1'b0, hw_q}));
      pt_q    <= SP_W'(rat[1]) * SP_W'($signed({1'b0, hh_q}));
      pb_q    <= SP_W'(rat[2]) * SP_W'($signed({1'b0, hh_q}));
    end
  end

  // ---------------- P2: screen coordinates ----------------
  logic                 pv2_q, pvis2_q;
  logic signed [SW-1:0] sx_q, st_q, df_q;
  logic signed [SW-1:0] hw_s, hh_s;

  assign hw_s = SW'(hw_q) << SCREEN_BITS;
  assign hh_s = SW'(hh_q) << SCREEN_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv2_q <= 1'b0;
    else if (adv) pv2_q <= pv1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pvis2_q <= pvis1_q;
      sx_q    <= hw_s + SW'(px_q);
      st_q    <= hh_s - SW'(pt_q);
      df_q    <= SW'(pt_q) - SW'(pb_q);   // bottom minus top
    end
  end

  // ---------------- output register ----------------
  logic                    out_vis_q;
  logic [BOX_W-1:0]        out_left_q, out_top_q, out_width_q, out_height_q;
  logic signed [LW-1:0]    left_num;

  assign left_num = (LW'(sx_q) <<< 2) - LW'(df_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= pv2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_vis_q <= pvis2_q;
      if (pvis2_q) begin
        out_left_q   <= trunc_sat(left_num, int'(SCREEN_BITS) + 2);
        out_top_q    <= trunc_sat(LW'(st_q), int'(SCREEN_BITS));
        out_width_q  <= trunc_sat(LW'(df_q), int'(SCREEN_BITS) + 1);
        out_height_q <= trunc_sat(LW'(df_q), int'(SCREEN_BITS));
      end else begin
        out_left_q   <= '0;
        out_top_q    <= '0;
        out_width_q  <= '0;
        out_height_q <= '0;
      end
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.visible    = out_vis_q;
  assign out_o.box_left   = out_left_q;
  assign out_o.box_top    = out_top_q;
  assign out_o.box_width  = out_width_q;
  assign out_o.box_height = out_height_q;

endmodule

FILE: src/pbp_checker.sv
// Port-level checks of the box projection block and their bind.
`include "perspective_box_projection_assert.svh"

module pbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_visible_i,
  input logic [15:0] box_left_i,
  input logic [15:0] box_top_i,
  input logic [15:0] box_width_i,
  input logic [15:0] box_height_i
);

  // hidden points carry an all-zero box
  `PBP_ASSERT(a_hidden_zero, out_valid_i && !out_visible_i |-> (box_left_i == 16'd0 && box_top_i == 16'd0 && box_width_i == 16'd0 && box_height_i == 16'd0), "hidden point with nonzero box")

  `PBP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_visible_i) && $stable(box_left_i) && $stable(box_top_i) && $stable(box_width_i) && $stable(box_height_i), "stalled result changed")

  // input side stalls only behind a waiting result
  `PBP_ASSERT(a_stall_cause, !in_ready_i |-> out_valid_i && !out_ready_i, "input stalled without output back-pressure")

  `PBP_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_valid_i, "result shown during reset")

endmodule

bind perspective_box_projection pbp_checker u_pbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_visible_i (out_o.visible),
  .box_left_i    (out_o.box_left),
  .box_top_i     (out_o.box_top),
  .box_width_i   (out_o.box_width),
  .box_height_i  (out_o.box_height)
);
